[hdl/ets2c_pkg.sv]
// ets2c_pkg: widths, constants, types and the month length table
// for the epoch-seconds to calendar converter; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ets2c_pkg;

  localparam int EpochW = 32;
  localparam int OffsW  = 16;
  localparam int YearW  = 12;
  localparam int MonW   = 4;
  localparam int DayW   = 5;
  localparam int HourW  = 5;
  localparam int MinW   = 6;
  localparam int SecW   = 6;
  localparam int AluW   = 32;  // holds the local seconds count being stepped down

  localparam logic [AluW-1:0]  SecsPerLeapYr = AluW'(31622400);
  localparam logic [AluW-1:0]  SecsPerYear   = AluW'(31536000);
  localparam logic [AluW-1:0]  SecsPer31Days = AluW'(2678400);
  localparam logic [AluW-1:0]  SecsPer30Days = AluW'(2592000);
  localparam logic [AluW-1:0]  SecsPer29Days = AluW'(2505600);
  localparam logic [AluW-1:0]  SecsPer28Days = AluW'(2419200);
  localparam logic [AluW-1:0]  SecsPerDay    = AluW'(86400);
  localparam logic [AluW-1:0]  SecsPerHour   = AluW'(3600);
  localparam logic [AluW-1:0]  SecsPerMin    = AluW'(60);
  localparam logic [YearW-1:0] EpochYear     = YearW'(1970);
  localparam logic [6:0]       EpochMod100   = 7'd70;
  localparam logic [8:0]       EpochMod400   = 9'd370;
  localparam logic [OffsW-1:0] OffsetReset   = OffsW'(28800);
  localparam logic [MonW-1:0]  LastMonth     = MonW'(11);

  typedef struct packed {
    logic [AluW-1:0] a;
    logic [AluW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [AluW-1:0] diff;
    logic            ge;
  } alu_rsp_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [MonW-1:0]  month;
    logic [DayW-1:0]  day;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
  } res_t;

  // seconds in a month, index 0 is january
  function automatic logic [AluW-1:0] month_secs(input logic [MonW-1:0] idx,
                                                 input logic leap);
    logic [AluW-1:0] len;
    unique case (idx)
      4'd1:                      len = leap ? SecsPer29Days : SecsPer28Days;
      4'd3, 4'd5, 4'd8, 4'd10:   len = SecsPer30Days;
      default:                   len = SecsPer31Days;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

[hdl/ets2c_if.sv]
// ets2c channel interfaces: input item, result item and offset write
// depends on ets2c_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ets2c_in_if import ets2c_pkg::*;;
  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;
  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface ets2c_out_if import ets2c_pkg::*;;
  logic             valid;
  logic             ready;
  logic [YearW-1:0] year;
  logic [MonW-1:0]  month;
  logic [DayW-1:0]  day;
  logic [HourW-1:0] hour;
  logic [MinW-1:0]  minute;
  logic [SecW-1:0]  second;
  modport source (output valid, output year, output month, output day, output hour,
                  output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day, input hour,
                  input minute, input second, output ready);
endinterface

interface ets2c_cfg_if import ets2c_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OffsW-1:0] local_offset_seconds;
  modport source (output valid, output local_offset_seconds, input ready);
  modport sink   (input valid, input local_offset_seconds, output ready);
endinterface

`default_nettype wire

[hdl/ets2c_alu.sv]
// ets2c_alu: shared compare-and-subtract unit used by every sequencer step
// depends on ets2c_pkg
`timescale 1ns / 1ps
`default_nettype none

module ets2c_alu import ets2c_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [AluW:0] wide;

  assign wide       = {1'b0, req_i.a} - {1'b0, req_i.b};
  assign rsp_o.diff = wide[AluW-1:0];
  assign rsp_o.ge   = ~wide[AluW];

endmodule

`default_nettype wire

[hdl/ets2c_seq.sv]
// ets2c_seq: sequencer and working registers; steps whole years, months,
// days, hours and minutes off the local seconds count; depends on ets2c_pkg
`timescale 1ns / 1ps
`default_nettype none

module ets2c_seq import ets2c_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [EpochW-1:0] epoch_i,
  input  logic [OffsW-1:0]  offset_i,
  input  logic              take_i,
  output alu_req_t          alu_req_o,
  input  alu_rsp_t          alu_rsp_i,
  output seq_stat_t         stat_o,
  output res_t              res_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StYear  = 3'd1;
  localparam logic [2:0] StMonth = 3'd2;
  localparam logic [2:0] StDay   = 3'd3;
  localparam logic [2:0] StHour  = 3'd4;
  localparam logic [2:0] StMin   = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic [EpochW-1:0] t_q, t_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [6:0]        y100_q, y100_d;
  logic [8:0]        y400_q, y400_d;
  logic [MonW-1:0]   mon_q, mon_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [MinW-1:0]   min_q, min_d;

  logic              leap;

  assign leap = (year_q[1:0] == 2'd0) && ((y100_q != 7'd0) || (y400_q == 9'd0));

  always_comb begin
    alu_req_o.a = t_q;
    unique case (state_q)
      StYear:  alu_req_o.b = leap ? SecsPerLeapYr : SecsPerYear;
      StMonth: alu_req_o.b = month_secs(mon_q, leap);
      StDay:   alu_req_o.b = SecsPerDay;
      StHour:  alu_req_o.b = SecsPerHour;
      StMin:   alu_req_o.b = SecsPerMin;
      default: alu_req_o.b = SecsPerDay;
    endcase
  end

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    year_d  = year_q;
    y100_d  = y100_q;
    y400_d  = y400_q;
    mon_d   = mon_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          t_d     = epoch_i + {{(EpochW-OffsW){1'b0}}, offset_i};
          year_d  = EpochYear;
          y100_d  = EpochMod100;
          y400_d  = EpochMod400;
          mon_d   = '0;
          day_d   = '0;
          hour_d  = '0;
          min_d   = '0;
          state_d = StYear;
        end
      end
      StYear: begin
        if (alu_rsp_i.ge) begin
          t_d    = alu_rsp_i.diff;
          year_d = year_q + YearW'(1);
          y100_d = (y100_q == 7'd99) ? 7'd0 : y100_q + 7'd1;
          y400_d = (y400_q == 9'd399) ? 9'd0 : y400_q + 9'd1;
        end else begin
          state_d = StMonth;
        end
      end
      StMonth: begin
        if (alu_rsp_i.ge && (mon_q != LastMonth)) begin
          t_d   = alu_rsp_i.diff;
          mon_d = mon_q + MonW'(1);
        end else begin
          state_d = StDay;
        end
      end
      StDay: begin
        if (alu_rsp_i.ge) begin
          t_d   = alu_rsp_i.diff;
          day_d = day_q + DayW'(1);
        end else begin
          state_d = StHour;
        end
      end
      StHour: begin
        if (alu_rsp_i.ge) begin
          t_d    = alu_rsp_i.diff;
          hour_d = hour_q + HourW'(1);
        end else begin
          state_d = StMin;
        end
      end
      StMin: begin
        if (alu_rsp_i.ge) begin
          t_d   = alu_rsp_i.diff;
          min_d = min_q + MinW'(1);
        end else begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (take_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    year_q <= year_d;
    y100_q <= y100_d;
    y400_q <= y400_d;
    mon_q  <= mon_d;
    day_q  <= day_d;
    hour_q <= hour_d;
    min_q  <= min_d;
  end

  assign stat_o.busy = (state_q != StIdle);
  assign stat_o.done = (state_q == StDone);

  // what is left after the minutes are stepped off is below 60
  assign res_o.year   = year_q;
  assign res_o.month  = mon_q + MonW'(1);
  assign res_o.day    = day_q + DayW'(1);
  assign res_o.hour   = hour_q;
  assign res_o.minute = min_q;
  assign res_o.second = t_q[SecW-1:0];

endmodule

`default_nettype wire

[hdl/epoch_seconds_to_calendar_unit.sv]
// conversion steps: the shared compare-subtract unit takes one step per whole year since 1970,
// whole month, whole day, whole hour and whole minute, plus one closing step for each field
// throughput: one item at a time, next item can be taken in the cycle after the result is loaded
// reset: async active low, offset back to 28800
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_unit import ets2c_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ets2c_in_if.sink          in_i,
  ets2c_cfg_if.sink         cfg_i,
  ets2c_out_if.source       out_o
);

  // local time offset register, sampled when an item is accepted
  logic [OffsW-1:0] offset_q;

  // sequencer and shared arithmetic unit
  alu_req_t  alu_req;
  alu_rsp_t  alu_rsp;
  seq_stat_t seq_stat;
  res_t      seq_res;
  logic      start;
  logic      take;

  // output register, frees the sequencer while a result waits
  logic      out_valid_q, out_valid_d;
  res_t      res_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      offset_q <= cfg_i.local_offset_seconds;
    end
  end

  // a new item is taken only while the sequencer is idle
  assign in_i.ready = ~seq_stat.busy;
  assign start      = in_i.valid & in_i.ready;

  // result moves to the output register once that slot is free
  assign take = seq_stat.done & (~out_valid_q | out_o.ready);

  ets2c_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  ets2c_seq u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .epoch_i   (in_i.epoch_seconds),
    .offset_i  (offset_q),
    .take_i    (take),
    .alu_req_o (alu_req),
    .alu_rsp_i (alu_rsp),
    .stat_o    (seq_stat),
    .res_o     (seq_res)
  );

  assign out_valid_d = take | (out_valid_q & ~out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= seq_res;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.year   = res_q.year;
  assign out_o.month  = res_q.month;
  assign out_o.day    = res_q.day;
  assign out_o.hour   = res_q.hour;
  assign out_o.minute = res_q.minute;
  assign out_o.second = res_q.second;

  // an accepted item keeps the sequencer busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> seq_stat.busy)
    else $error("sequencer not busy after item accepted");

  // a finished result waits in the sequencer while the output slot is full
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_stat.done && !take |=> seq_stat.done)
    else $error("finished result dropped");

  // result fields stay in range
  a_fields_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.month >= 4'd1) && (res_q.month <= 4'd12) &&
                    (res_q.hour < 5'd24) && (res_q.minute < 6'd60) &&
                    (res_q.second < 6'd60) && (res_q.day != 5'd0))
    else $error("result field out of range");

endmodule

`default_nettype wire

[sim/ets2c_calendar_checker.sv]
// ets2c_calendar_checker: watches the input, offset and result channels of the
// epoch-seconds to calendar converter, predicts each date and compares it
// depends on ets2c_pkg and the channel interfaces in ets2c_if.sv
`timescale 1ns / 1ps

module ets2c_calendar_checker import ets2c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  ets2c_in_if         in_mon,
  ets2c_cfg_if        cfg_mon,
  ets2c_out_if        res_mon,
  output int unsigned fails_o,
  output int unsigned pending_o,
  output int unsigned checked_o
);

  logic [OffsW-1:0] offset_q;
  res_t             dates_q[$];

  function automatic bit leap_year(input int unsigned y);
    if ((y % 4) != 0) return 1'b0;
    if ((y % 100) != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int unsigned days_of_month(input int unsigned m, input bit leap);
    case (m)
      1:          return leap ? 29 : 28;
      3, 5, 8, 10: return 30;
      default:    return 31;
    endcase
  endfunction

  // local date and time of an epoch count shifted by the offset, sum wraps at 2^32
  function automatic res_t to_calendar(input logic [EpochW-1:0] epoch,
                                       input logic [OffsW-1:0] offs);
    logic [EpochW-1:0] t;
    int unsigned       days;
    int unsigned       secs;
    int unsigned       yr;
    int unsigned       mo;
    res_t              r;
    t    = epoch + EpochW'(offs);
    days = t / 86400;
    secs = t % 86400;
    yr   = 1970;
    while (days >= (leap_year(yr) ? 366 : 365)) begin
      days -= leap_year(yr) ? 366 : 365;
      yr++;
    end
    mo = 0;
    while (mo < 11 && days >= days_of_month(mo, leap_year(yr))) begin
      days -= days_of_month(mo, leap_year(yr));
      mo++;
    end
    r.year   = YearW'(yr);
    r.month  = MonW'(mo + 1);
    r.day    = DayW'(days + 1);
    r.hour   = HourW'(secs / 3600);
    r.minute = MinW'((secs % 3600) / 60);
    r.second = SecW'(secs % 60);
    return r;
  endfunction

  function automatic int unsigned field_diff(input string name, input int unsigned want,
                                             input int unsigned got);
    if (want == got) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t        want;
    res_t        got;
    int unsigned errs;
    if (!rst_ni) begin
      offset_q  <= OffsetReset;
      dates_q.delete();
      fails_o   <= 0;
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      errs = 0;
      if (cfg_mon.valid && cfg_mon.ready) offset_q <= cfg_mon.local_offset_seconds;
      if (in_mon.valid && in_mon.ready)
        dates_q.push_back(to_calendar(in_mon.epoch_seconds, offset_q));
      if (res_mon.valid && res_mon.ready) begin
        got.year   = res_mon.year;
        got.month  = res_mon.month;
        got.day    = res_mon.day;
        got.hour   = res_mon.hour;
        got.minute = res_mon.minute;
        got.second = res_mon.second;
        if (dates_q.size() == 0) begin
          $error("result %0d-%0d-%0d with no date pending", got.year, got.month, got.day);
          errs = 1;
        end else begin
          want = dates_q.pop_front();
          errs += field_diff("year",   want.year,   got.year);
          errs += field_diff("month",  want.month,  got.month);
          errs += field_diff("day",    want.day,    got.day);
          errs += field_diff("hour",   want.hour,   got.hour);
          errs += field_diff("minute", want.minute, got.minute);
          errs += field_diff("second", want.second, got.second);
        end
        checked_o <= checked_o + 1;
      end
      fails_o   <= fails_o + errs;
      pending_o <= dates_q.size();
    end
  end

endmodule

[sim/tb_epoch_seconds_to_calendar_unit.sv]
// tb_epoch_seconds_to_calendar_unit: drives epoch counts and offset writes into the
// converter with random gaps and result stalls and gives the verdict
// depends on ets2c_pkg, ets2c_if.sv, the converter and ets2c_calendar_checker
`timescale 1ns / 1ps

module tb_epoch_seconds_to_calendar_unit;
  import ets2c_pkg::*;

  // covers the worst-case conversion latency, plus margin
  localparam int DrainCycles = 300;
  localparam int ItemsPerPhase = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned fails;
  int unsigned pending;
  int unsigned checked;

  // when quiet is set neither side idles; calm phases also run without gaps
  bit quiet = 1'b0;
  bit calm = 1'b0;
  int unsigned phases = 1;
  logic [OffsW-1:0] offset_now = OffsetReset;

  ets2c_in_if  in_ch ();
  ets2c_out_if res_ch ();
  ets2c_cfg_if cfg_ch ();

  epoch_seconds_to_calendar_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (res_ch)
  );

  ets2c_calendar_checker mon (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon    (in_ch),
    .cfg_mon   (cfg_ch),
    .res_mon   (res_ch),
    .fails_o   (fails),
    .pending_o (pending),
    .checked_o (checked)
  );

  always #2 clk_i = ~clk_i;

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("FAIL epoch_seconds_to_calendar_unit");
    $finish;
  end

  // result side: ready drops for bursts of random length, changes at the falling edge
  initial begin
    int unsigned stall;
    stall = 0;
    res_ch.ready = 1'b1;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        res_ch.ready = 1'b0;
        stall--;
      end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
        res_ch.ready = 1'b0;
        stall = $urandom_range(1, 11) - 1;
      end else begin
        res_ch.ready = 1'b1;
      end
    end
  end

  // one epoch count; valid stays high when the next item follows without a gap
  task automatic send_epoch(input logic [EpochW-1:0] t);
    if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_ch.valid = 1'b1;
    in_ch.epoch_seconds = t;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  // drain every pending date, let the block settle, then load a new offset
  task automatic set_offset(input logic [OffsW-1:0] offs);
    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_ch.valid = 1'b1;
    cfg_ch.local_offset_seconds = offs;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid = 1'b0;
    offset_now = offs;
    phases++;
  endtask

  // mix of fully random counts, local midnights, last seconds of a day, times within a day,
  // and counts near the top where the offset sum wraps
  function automatic logic [EpochW-1:0] pick_epoch();
    int unsigned       kind;
    logic [EpochW-1:0] v;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      v = $urandom;
    end else if (kind < 8) begin
      v = EpochW'($urandom_range(0, 49710)) * 32'd86400;
      case ($urandom_range(0, 2))
        0:       v = v - EpochW'(offset_now);
        1:       v = v + 32'd86399 - EpochW'(offset_now);
        default: v = v + EpochW'($urandom_range(0, 86399));
      endcase
    end else begin
      v = 32'hFFFF_FFFF - EpochW'($urandom_range(0, 70000));
    end
    return v;
  endfunction

  task automatic random_phase(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_epoch(pick_epoch());
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.epoch_seconds = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.local_offset_seconds = '0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at the reset offset of eight hours; boundaries are local times
    send_epoch(32'd0);
    send_epoch(32'hFFFF_FFFF);                          // sum wraps past 2^32
    send_epoch(32'd4294938496);                         // wraps to local 1970-01-01 00:00:00
    send_epoch(32'd4294938495);                         // top of the range, 2106
    send_epoch(32'd951782399 - 32'd28800);              // 2000-02-28 23:59:59
    send_epoch(32'd951782400 - 32'd28800);              // leap day of a 400th year
    send_epoch(32'd978307199 - 32'd28800);              // day 366 of 2000
    send_epoch(32'd4107542399 - 32'd28800);             // 2100-02-28, century not leap
    send_epoch(32'd4107542400 - 32'd28800);             // 2100-03-01
    send_epoch(32'd68169600 - 32'd28800);               // 1972-02-29
    send_epoch(32'd94694399 - 32'd28800);               // 1972-12-31 23:59:59
    send_epoch(32'd946684799 - 32'd28800);              // 1999-12-31 23:59:59
    send_epoch(32'd4260211199 - 32'd28800);             // 2104-12-31, last leap year
    send_epoch(32'h7FFF_FFFF);
    send_epoch(32'h8000_0000);
    send_epoch(32'h5555_5555);
    send_epoch(32'hAAAA_AAAA);
    send_epoch(32'd86399 - 32'd28800 + 32'd86400 * 32'd58);  // last second of february 1970

    random_phase(ItemsPerPhase);

    // offset at zero: the plain UTC conversion and the true top of the range
    set_offset('0);
    send_epoch(32'hFFFF_FFFF);
    send_epoch(32'd0);
    calm = 1'b1;
    random_phase(ItemsPerPhase);
    calm = 1'b0;

    // all ones, above the intended range
    set_offset('1);
    send_epoch(32'hFFFF_FFFF);
    random_phase(ItemsPerPhase);

    // highest intended offset, fourteen hours
    set_offset(OffsW'(50400));
    send_epoch(32'hFFFF_3B1F);
    random_phase(ItemsPerPhase);

    set_offset(OffsW'($urandom_range(0, 50400)));
    random_phase(ItemsPerPhase);

    set_offset(OffsW'($urandom));
    random_phase(ItemsPerPhase);

    // back to eight hours; the last stretch runs without idling
    set_offset(OffsetReset);
    random_phase(ItemsPerPhase - 20);
    quiet = 1'b1;
    random_phase(40);

    in_ch.valid = 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(negedge clk_i);

    $display("converted %0d epoch counts over %0d offset settings,", checked, phases);
    $display("including leap days, century years and wrap past 2^32");
    if (fails == 0) begin
      $display("PASS epoch_seconds_to_calendar_unit");
    end else begin
      $display("FAIL epoch_seconds_to_calendar_unit");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ets2c_pkg.sv
hdl/ets2c_if.sv
hdl/ets2c_alu.sv
hdl/ets2c_seq.sv
hdl/epoch_seconds_to_calendar_unit.sv
sim/ets2c_calendar_checker.sv
sim/tb_epoch_seconds_to_calendar_unit.sv
